>>> rtl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg: shared types for the sorted key table
// item and result layouts, command and status codes, cell control bundle
// ----------------------------------------------------------------------------
`default_nettype none

package skt_pkg;

  localparam int KEY_W       = 31;
  localparam int IN_PAY_W    = 32;
  localparam int OUT_PAY_W   = 32;
  localparam int OUT_COUNT_W = 7;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    cmd_t                cmd;
    logic [KEY_W-1:0]    key;
    logic [IN_PAY_W-1:0] payload;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [OUT_PAY_W-1:0]   payload_out;
    logic [OUT_COUNT_W-1:0] entry_count;
  } out_item_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic             compare;
    logic             apply;
    cmd_t             cmd;
    logic [KEY_W-1:0] key;
    logic             not_full;
    logic             found;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/skt_cell.sv
// ----------------------------------------------------------------------------
// skt_cell: one entry of the sorted key table
// holds a key and payload, compares against the broadcast key and shifts
// to or from its neighbours on insert and delete
// ----------------------------------------------------------------------------
`default_nettype none

module skt_cell #(
  parameter int PAYLOAD_BITS = 32
) (
  input  wire logic                     clk,
  input  wire skt_pkg::cell_ctrl_t      ctrl,
  input  wire logic                     valid,
  input  wire logic [PAYLOAD_BITS-1:0]  new_payload,
  input  wire logic [skt_pkg::KEY_W-1:0] left_key,
  input  wire logic [PAYLOAD_BITS-1:0]  left_payload,
  input  wire logic                     left_flag,
  input  wire logic [skt_pkg::KEY_W-1:0] right_key,
  input  wire logic [PAYLOAD_BITS-1:0]  right_payload,
  output logic [skt_pkg::KEY_W-1:0]     key,
  output logic [PAYLOAD_BITS-1:0]       payload,
  output logic                          flag,
  output logic                          hit
);

  import skt_pkg::*;

  logic eq;

  // flag marks the cells at or after the target position
  always_ff @(posedge clk) begin
    if (ctrl.compare) begin
      if (ctrl.cmd == CMD_INSERT) begin
        flag <= !valid || (key > ctrl.key);
      end else begin
        flag <= valid && (key >= ctrl.key);
      end
      eq <= (key == ctrl.key);
    end
  end

  // first cell at or after the lower bound, holding the key itself
  assign hit = flag && !left_flag && eq;

  always_ff @(posedge clk) begin
    if (ctrl.apply) begin
      case (ctrl.cmd)
        CMD_INSERT: begin
          if (ctrl.not_full && flag) begin
            if (left_flag) begin
              key     <= left_key;
              payload <= left_payload;
            end else begin
              key     <= ctrl.key;
              payload <= new_payload;
            end
          end
        end
        CMD_UPDATE: begin
          if (hit) begin
            payload <= new_payload;
          end
        end
        CMD_DELETE: begin
          if (ctrl.found && flag) begin
            key     <= right_key;
            payload <= right_payload;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table: ordered key/payload table with insert, lookup, update
// and delete, built as a row of compare-and-shift cells
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Each item gives
// exactly one result, shown on result for a single cycle with done high;
// the receiver cannot stall, so it must take the result in that cycle.
// The item is captured in the cycle in which it is taken; then, in S_CMP,
// every cell compares its key with the item's key in parallel, and then,
// in S_ACT, the cells shift, write or hold and the result is registered.
// No new item is taken before the last one's result is shown. busy drops
// in the cycle the result is shown, so a new item can be taken then.
// Insert places the record after any equal keys and is refused with a
// full status when the table holds CAPACITY entries. Lookup, update and
// delete act on the first entry holding the key. entry_count carries the
// low 7 bits of the count after the item. The table contents need no
// clearing after reset; only the sequencer state, count and done reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table #(
  parameter int CAPACITY     = 64,
  parameter int PAYLOAD_BITS = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire skt_pkg::in_item_t  item,
  output logic                    busy,
  output logic                    done,
  output skt_pkg::out_item_t      result
);

  import skt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // one-hot sequencer
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_ACT  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  in_item_t          item_q;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;

  logic [PAYLOAD_BITS-1:0] pay_in;
  logic [PAYLOAD_BITS-1:0] sel_payload;
  logic                    found;
  logic                    not_full;
  cell_ctrl_t              ctrl;
  out_item_t               result_next;

  // cell row outputs
  logic [KEY_W-1:0]        cell_key [CAPACITY];
  logic [PAYLOAD_BITS-1:0] cell_pay [CAPACITY];
  logic [CAPACITY-1:0]     cell_flag;
  logic [CAPACITY-1:0]     cell_hit;

  assign busy     = (state != S_IDLE);
  assign pay_in   = PAYLOAD_BITS'(item_q.payload);
  assign not_full = (count < CNT_W'(CAPACITY));
  assign found    = |cell_hit;

  // payload of the single hit cell, one-hot and-or
  always_comb begin
    sel_payload = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_payload = sel_payload | (cell_pay[i] & {PAYLOAD_BITS{cell_hit[i]}});
    end
  end

  always_comb begin
    ctrl.compare  = (state == S_CMP);
    ctrl.apply    = (state == S_ACT);
    ctrl.cmd      = item_q.cmd;
    ctrl.key      = item_q.key;
    ctrl.not_full = not_full;
    ctrl.found    = found;
  end

  // the row of cells; neighbours hand keys and payloads on
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    valid;
    logic [KEY_W-1:0]        l_key;
    logic [PAYLOAD_BITS-1:0] l_pay;
    logic                    l_flag;
    logic [KEY_W-1:0]        r_key;
    logic [PAYLOAD_BITS-1:0] r_pay;

    assign valid = (CNT_W'(i) < count);

    if (i == 0) begin : g_first
      assign l_key  = '0;
      assign l_pay  = '0;
      assign l_flag = 1'b0;
    end else begin : g_inner_left
      assign l_key  = cell_key[i-1];
      assign l_pay  = cell_pay[i-1];
      assign l_flag = cell_flag[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_key = cell_key[i];
      assign r_pay = cell_pay[i];
    end else begin : g_inner_right
      assign r_key = cell_key[i+1];
      assign r_pay = cell_pay[i+1];
    end

    skt_cell #(
      .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .valid         (valid),
      .new_payload   (pay_in),
      .left_key      (l_key),
      .left_payload  (l_pay),
      .left_flag     (l_flag),
      .right_key     (r_key),
      .right_payload (r_pay),
      .key           (cell_key[i]),
      .payload       (cell_pay[i]),
      .flag          (cell_flag[i]),
      .hit           (cell_hit[i])
    );
  end

  // result and count for the item in its last cycle
  always_comb begin
    count_next              = count;
    result_next.status      = ST_OK;
    result_next.payload_out = '0;
    if (item_q.cmd == CMD_INSERT) begin
      if (not_full) begin
        count_next              = count + CNT_W'(1);
        result_next.payload_out = OUT_PAY_W'(pay_in);
      end else begin
        result_next.status = ST_FULL;
      end
    end else if (!found) begin
      result_next.status = ST_NOT_FOUND;
    end else begin
      case (item_q.cmd)
        CMD_UPDATE: result_next.payload_out = OUT_PAY_W'(pay_in);
        CMD_DELETE: begin
          result_next.payload_out = OUT_PAY_W'(sel_payload);
          count_next              = count - CNT_W'(1);
        end
        default:    result_next.payload_out = OUT_PAY_W'(sel_payload);
      endcase
    end
    result_next.entry_count = OUT_COUNT_W'(count_next);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_CMP;
        end
      end
      S_CMP:   state_next = S_ACT;
      S_ACT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_ACT);
      if (state == S_ACT) begin
        count <= count_next;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_q <= item;
    end
    if (state == S_ACT) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/sorted_key_table_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_test: self-checking bench for the sorted key table
// sends insert, lookup, update and delete items through the start/busy
// handshake, keeps a shadow copy of the table to predict every result and
// checks each result field by field; a short table of directed rows comes
// first, then a fill to capacity and a drain, then randomised traffic that
// swings between filling and emptying under several sender idling phases
// ----------------------------------------------------------------------------
module sorted_key_table_test;
  import skt_pkg::*;

  localparam int CAPACITY     = 64;
  localparam int SETTLE_TICKS = 10;    // idle wait after the drain loop
  localparam int DRAIN_LIMIT  = 1000;
  localparam int PHASE_ITEMS  = 400;
  localparam logic [KEY_W-1:0] KEY_TOP = '1;

  // one directed row: the item, and a hand-typed result where it is obvious
  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      start;
  in_item_t  item;
  logic      busy;
  logic      done;
  out_item_t result;

  // shadow of the table contents, kept in ascending key order
  logic [KEY_W-1:0]    shadow_keys [CAPACITY];
  logic [IN_PAY_W-1:0] shadow_pays [CAPACITY];
  int                  shadow_count;

  // results owed by the block, oldest first
  out_item_t pending_outcomes [$];
  int        mismatches;

  // stimulus shaping knobs
  int idle_pct;
  bit fill_bias;
  int epoch_left;

  sorted_key_table #(
    .CAPACITY    (CAPACITY),
    .PAYLOAD_BITS(32)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .item  (item),
    .busy  (busy),
    .done  (done),
    .result(result)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // apply one item to the shadow table and return the result it should give
  function automatic out_item_t shadow_execute(in_item_t it);
    out_item_t r;
    int        pos;
    int        i;
    r.status      = ST_OK;
    r.payload_out = '0;
    if (it.cmd == CMD_INSERT) begin
      if (shadow_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        // new record goes after every equal key
        pos = 0;
        while (pos < shadow_count && shadow_keys[pos] <= it.key) pos++;
        for (i = shadow_count; i > pos; i--) begin
          shadow_keys[i] = shadow_keys[i-1];
          shadow_pays[i] = shadow_pays[i-1];
        end
        shadow_keys[pos] = it.key;
        shadow_pays[pos] = it.payload;
        shadow_count++;
        r.payload_out = it.payload;
      end
    end else begin
      // first entry in table order holding the key
      pos = 0;
      while (pos < shadow_count && shadow_keys[pos] < it.key) pos++;
      if (pos >= shadow_count || shadow_keys[pos] != it.key) begin
        r.status = ST_NOT_FOUND;
      end else begin
        case (it.cmd)
          CMD_LOOKUP: begin
            r.payload_out = shadow_pays[pos];
          end
          CMD_UPDATE: begin
            shadow_pays[pos] = it.payload;
            r.payload_out    = it.payload;
          end
          default: begin
            // delete closes the gap
            r.payload_out = shadow_pays[pos];
            for (i = pos; i + 1 < shadow_count; i++) begin
              shadow_keys[i] = shadow_keys[i+1];
              shadow_pays[i] = shadow_pays[i+1];
            end
            shadow_count--;
          end
        endcase
      end
    end
    r.entry_count = OUT_COUNT_W'(shadow_count);
    return r;
  endfunction

  function automatic dir_row_t row(cmd_t c, logic [KEY_W-1:0] k,
                                   logic [IN_PAY_W-1:0] p, bit typed,
                                   logic [1:0] st, logic [OUT_PAY_W-1:0] po,
                                   logic [OUT_COUNT_W-1:0] cnt);
    dir_row_t d;
    d.item.cmd         = c;
    d.item.key         = k;
    d.item.payload     = p;
    d.typed            = typed;
    d.want.status      = st;
    d.want.payload_out = po;
    d.want.entry_count = cnt;
    return d;
  endfunction

  // mostly keys already stored or from a small pool, so hits and
  // duplicates are common; the rest spread over the whole key range
  function automatic logic [KEY_W-1:0] pick_key();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55 && shadow_count > 0) return shadow_keys[$urandom_range(shadow_count - 1)];
    if (roll < 85) begin
      case ($urandom_range(7))
        0: return '0;
        1: return KEY_W'(1);
        2: return KEY_W'(2);
        3: return KEY_W'(100);
        4: return KEY_W'(101);
        5: return KEY_W'(32'h4000_0000);
        6: return KEY_TOP - KEY_W'(1);
        default: return KEY_TOP;
      endcase
    end
    return KEY_W'($urandom);
  endfunction

  // the bias flips between epochs so the table swings between empty and full
  function automatic cmd_t pick_cmd();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return fill_bias ? CMD_INSERT : CMD_DELETE;
    if (roll < 70) return fill_bias ? CMD_DELETE : CMD_INSERT;
    if (roll < 85) return CMD_LOOKUP;
    return CMD_UPDATE;
  endfunction

  // present one item, hold it until taken, then book its expected result;
  // start stays high on return so back-to-back items need no extra cycle
  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    out_item_t predicted;
    int        gap;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = shadow_execute(it);
    pending_outcomes.push_back(typed ? want : predicted);
  endtask

  // sender holds off until every owed result has come back
  task automatic pause_until_settled();
    start <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // result checker: the receiver cannot stall, so every strobe is a result
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && done === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result: status %0d payload_out %h entry_count %0d",
                 $realtime, result.status, result.payload_out, result.entry_count);
        mismatches++;
      end else begin
        want = pending_outcomes.pop_front();
        if (result.status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $realtime, want.status, result.status);
          mismatches++;
        end
        if (result.payload_out !== want.payload_out) begin
          $display("%0t: payload_out mismatch: expected %h, actual %h",
                   $realtime, want.payload_out, result.payload_out);
          mismatches++;
        end
        if (result.entry_count !== want.entry_count) begin
          $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                   $realtime, want.entry_count, result.entry_count);
          mismatches++;
        end
      end
    end
  end

  initial begin
    dir_row_t  rows [$];
    in_item_t  it;
    out_item_t full_want;
    int        n;
    int        ph;
    int        guard;

    rst          = 1'b1;
    start        = 1'b0;
    item         = '0;
    mismatches   = 0;
    idle_pct     = 0;
    shadow_count = 0;
    fill_bias    = 1'b0;
    epoch_left   = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // misses on an empty table
    rows.push_back(row(CMD_LOOKUP, KEY_TOP, '0, 1'b1, ST_NOT_FOUND, '0, '0));
    rows.push_back(row(CMD_UPDATE, '0, '1, 1'b1, ST_NOT_FOUND, '0, '0));
    rows.push_back(row(CMD_DELETE, '0, '0, 1'b1, ST_NOT_FOUND, '0, '0));
    // extreme keys and payloads, then a duplicate of the top key
    rows.push_back(row(CMD_INSERT, KEY_TOP, '1, 1'b1, ST_OK, '1, 7'd1));
    rows.push_back(row(CMD_INSERT, '0, '0, 1'b1, ST_OK, '0, 7'd2));
    rows.push_back(row(CMD_INSERT, KEY_TOP, 32'h1234_5678, 1'b1, ST_OK, 32'h1234_5678, 7'd3));
    // duplicates: the earliest inserted is found first
    rows.push_back(row(CMD_LOOKUP, KEY_TOP, '0, 1'b1, ST_OK, '1, 7'd3));
    rows.push_back(row(CMD_INSERT, KEY_W'(32'h4000_0000), '0, 1'b0, ST_OK, '0, '0));
    rows.push_back(row(CMD_UPDATE, KEY_TOP, 32'h5a5a_5a5a, 1'b0, ST_OK, '0, '0));
    rows.push_back(row(CMD_LOOKUP, KEY_TOP, 32'hdead_beef, 1'b0, ST_OK, '0, '0));
    rows.push_back(row(CMD_DELETE, KEY_TOP, '1, 1'b0, ST_OK, '0, '0));
    rows.push_back(row(CMD_LOOKUP, KEY_TOP, '0, 1'b0, ST_OK, '0, '0));
    // miss on a key that falls between stored ones
    rows.push_back(row(CMD_LOOKUP, KEY_W'(1), '0, 1'b0, ST_OK, '0, '0));
    rows.push_back(row(CMD_UPDATE, '0, 32'h8000_0001, 1'b0, ST_OK, '0, '0));
    rows.push_back(row(CMD_DELETE, '0, '0, 1'b0, ST_OK, '0, '0));
    rows.push_back(row(CMD_DELETE, '0, '0, 1'b0, ST_OK, '0, '0));
    rows.push_back(row(CMD_LOOKUP, KEY_W'(32'h4000_0000), '0, 1'b0, ST_OK, '0, '0));
    rows.push_back(row(CMD_DELETE, KEY_W'(32'h4000_0000), '0, 1'b0, ST_OK, '0, '0));
    rows.push_back(row(CMD_DELETE, KEY_TOP, '0, 1'b0, ST_OK, '0, '0));
    rows.push_back(row(CMD_LOOKUP, KEY_TOP, '0, 1'b0, ST_OK, '0, '0));

    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].want);

    // fill to capacity with many equal keys, then push past it
    for (n = 0; n < CAPACITY; n++) begin
      it.cmd     = CMD_INSERT;
      it.key     = ($urandom_range(7) == 0) ? KEY_TOP : KEY_W'($urandom_range(40));
      it.payload = $urandom;
      send_item(it, 1'b0, '0);
    end
    full_want.status      = ST_FULL;
    full_want.payload_out = '0;
    full_want.entry_count = OUT_COUNT_W'(CAPACITY);
    it.cmd     = CMD_INSERT;
    it.key     = '0;
    it.payload = '1;
    send_item(it, 1'b1, full_want);
    it.key = KEY_TOP;
    send_item(it, 1'b1, full_want);
    // hits on a full table
    it.cmd = CMD_UPDATE;
    it.key = shadow_keys[CAPACITY-1];
    send_item(it, 1'b0, '0);
    it.cmd = CMD_LOOKUP;
    it.key = shadow_keys[0];
    send_item(it, 1'b0, '0);

    // drain from random positions so the gap closes from all over the table
    while (shadow_count > 0) begin
      it.cmd     = CMD_DELETE;
      it.key     = shadow_keys[$urandom_range(shadow_count - 1)];
      it.payload = $urandom;
      send_item(it, 1'b0, '0);
    end

    // the sender waits out every owed result at least once here
    pause_until_settled();

    // random traffic: no idling, heavy idling, light idling, no idling
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        1:       idle_pct = 68;
        2:       idle_pct = 18;
        default: idle_pct = 0;
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (epoch_left == 0) begin
          fill_bias  = !fill_bias;
          epoch_left = $urandom_range(40, 160);
        end
        epoch_left--;
        it.cmd     = pick_cmd();
        it.key     = pick_key();
        it.payload = $urandom;
        send_item(it, 1'b0, '0);
      end
      if (ph < 3) pause_until_settled();
    end

    // let the last results come home, bounded
    start <= 1'b0;
    guard = 0;
    while (pending_outcomes.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_TICKS) @(posedge clk);

    if (pending_outcomes.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $realtime, pending_outcomes.size());
    end
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
